/* rtl/osdm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the ordered store with delete-max.
// No dependencies.
package osdm_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_DELMAX = 2'd1;
  localparam opcode_t OP_LIST   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_DELETED  = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_LISTED   = 3'd4;

endpackage

/* rtl/ordered_store_delete_max.sv */
`timescale 1ns / 1ps
// Ordered store of signed values with insert-at-rear, delete-max and list.
// Depends on osdm_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall): one transaction carries opcode and
//    value. in_stall is high whenever the sequencer is busy; a new command is
//    taken only from the idle state. Opcode 3 is taken and ignored.
//  - Output channel (out_valid / out_stall): status, value_res, last. Every
//    command except opcode 3 gives one or more results; last marks the final
//    one. A one-deep output register sits between the sequencer and the
//    output, so a command can be taken while its predecessor's last result
//    still waits there.
//  - Sequencing: all work goes through one 16x32 array with one read port
//    (registered data) and one write port, and one signed comparator.
//    Insert writes unless full, then reports. Delete-max scans the n entries,
//    then moves each entry behind the maximum one place toward the front to
//    close the gap, then reports. List reads the entries in order. Empty cases report.
//  - Receiver stall: the sequencer waits on the output register; the list
//    walk re-reads the current entry until it can be handed over.
//  - Reset (rst, synchronous): store empty, sequencer idle, output empty.
//    Array contents are not cleared; only entries below the fill count are used.
module ordered_store_delete_max
  import osdm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               opcode,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] value_res,
  output logic                     last
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INS   = 7'b0000010,
    S_EMPTY = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_DEL   = 7'b0100000,
    S_LIST  = 7'b1000000
  } state_t;

  // Storage array, front at address 0.
  logic [DATA_W-1:0] mem [DEPTH];

  state_t              state, state_next;
  logic [DATA_W-1:0]   val, val_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   rd_idx;             // address whose data sits in rd_data
  logic [DATA_W-1:0]   rd_data;
  logic [DATA_W-1:0]   maxv, maxv_next;
  logic [ADDR_W-1:0]   best, best_next;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;

  logic                out_valid_next;
  status_t             status_next;
  logic [DATA_W-1:0]   value_res_next;
  logic                last_next;

  logic                out_free;
  logic                in_take;
  logic [CNT_W-1:0]    count_last;
  logic                at_end;
  logic                take;

  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign count_last = count - CNT_W'(1);
  assign at_end     = (CNT_W'(rd_idx) == count_last);
  // The one shared comparator: first entry always wins, later ones only if larger.
  assign take       = (rd_idx == '0) || ($signed(rd_data) > $signed(maxv));

  always_comb begin
    state_next     = state;
    val_next       = val;
    count_next     = count;
    maxv_next      = maxv;
    best_next      = best;
    rd_addr        = rd_idx;
    wr_en          = 1'b0;
    wr_addr        = count[ADDR_W-1:0];
    wr_data        = val;
    out_valid_next = out_valid && out_stall;
    status_next    = status;
    value_res_next = value_res;
    last_next      = last;

    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (in_take) begin
          val_next = value;
          unique case (opcode)
            OP_INSERT: state_next = S_INS;
            OP_DELMAX: state_next = (count == '0) ? S_EMPTY : S_SCAN;
            OP_LIST:   state_next = (count == '0) ? S_EMPTY : S_LIST;
            default:   state_next = S_IDLE;
          endcase
        end
      end

      S_INS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          value_res_next = '0;
          last_next      = 1'b1;
          if (count == CNT_W'(DEPTH)) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_INSERTED;
            wr_en       = 1'b1;
            wr_addr     = count[ADDR_W-1:0];
            wr_data     = val;
            count_next  = count + CNT_W'(1);
          end
          state_next = S_IDLE;
        end
      end

      S_EMPTY: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = ST_EMPTY;
          value_res_next = '0;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_SCAN: begin
        if (take) begin
          maxv_next = rd_data;
          best_next = rd_idx;
        end
        rd_addr = rd_idx + ADDR_W'(1);
        if (at_end) begin
          // Start closing the gap: fetch the entry just behind the maximum.
          rd_addr = best_next + ADDR_W'(1);
          state_next = (CNT_W'(best_next) == count_last) ? S_DEL : S_SHIFT;
        end
      end

      S_SHIFT: begin
        // rd_data holds entry rd_idx; move it one place toward the front.
        wr_en   = 1'b1;
        wr_addr = rd_idx - ADDR_W'(1);
        wr_data = rd_data;
        rd_addr = rd_idx + ADDR_W'(1);
        if (at_end) begin
          state_next = S_DEL;
        end
      end

      S_DEL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = ST_DELETED;
          value_res_next = maxv;
          last_next      = 1'b1;
          count_next     = count_last;
          state_next     = S_IDLE;
        end
      end

      S_LIST: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = ST_LISTED;
          value_res_next = rd_data;
          last_next      = at_end;
          rd_addr        = rd_idx + ADDR_W'(1);
          if (at_end) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    val       <= val_next;
    maxv      <= maxv_next;
    best      <= best_next;
    rd_idx    <= rd_addr;
    status    <= status_next;
    value_res <= value_res_next;
    last      <= last_next;
  end

  // Array: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/osdm_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for ordered_store_delete_max, attached by bind.
// Depends on osdm_pkg.
module osdm_checker
  import osdm_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [1:0]               opcode,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [2:0]               status,
  input logic signed [DATA_W-1:0] value_res,
  input logic                     last
);

  // A held result must not change under stall.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_res)
      && $stable(last))
    else $error("result changed while stalled");

  // A real command keeps the sequencer busy for at least the next cycle.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_INSERT || opcode == OP_DELMAX
      || opcode == OP_LIST) |=> in_stall)
    else $error("command accepted without going busy");

  // Only listed entries may be followed by more results.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_LISTED |-> last)
    else $error("single-result status without last");

  // Results without a value carry zero.
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED || status == ST_FULL || status == ST_EMPTY)
      |-> value_res == '0)
    else $error("nonzero value on valueless result");

endmodule

bind ordered_store_delete_max osdm_checker u_osdm_checker (.*);
